[rtl/ptns_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptns_pkg
// Shared types and codes for the point table nearest search unit.
// ----------------------------------------------------------------------------
package ptns_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int COORD_BITS_DEF = 10;
  localparam int ID_BITS        = 16;
  localparam int NEXT_ID_BITS   = ID_BITS + 1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_MISS    = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_EXHAUST = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH,
    S_ROOT
  } state_t;

endpackage
`default_nettype wire

[rtl/point_table_nearest_search_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_table_nearest_search_unit
// Point table with add, delete by identifier and nearest point query.
//
// A request is taken when start is high and busy is low. Its fields are
// in_operation, in_x_coord, in_y_coord and in_item_id. Every request gives
// exactly one result, shown for one cycle with out_valid high; the receiver
// cannot stall, so it must take the result in that cycle.
// Each request scans all CAPACITY slots through the coordinate memory, one
// slot per cycle, into a three stage distance and compare pipeline. A query
// that finds a point then runs a bit-pair square root on its squared
// distance. The single memory read port and the one shared distance
// datapath serve one request at a time; busy stays high throughout.
// A new request may be given in the cycle the result is shown.
// Reset empties the table and restarts identifiers at 1; no clearing pass
// is needed, since every slot has its own valid flop.
// ----------------------------------------------------------------------------
module point_table_nearest_search_unit #(
  parameter int CAPACITY   = ptns_pkg::CAPACITY_DEF,
  parameter int COORD_BITS = ptns_pkg::COORD_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [1:0]                           in_operation,
  input  wire logic [COORD_BITS-1:0]                in_x_coord,
  input  wire logic [COORD_BITS-1:0]                in_y_coord,
  input  wire logic [ptns_pkg::ID_BITS-1:0]         in_item_id,
  output logic                                      out_valid,
  output logic [1:0]                                out_status,
  output logic [ptns_pkg::ID_BITS-1:0]              out_result_id,
  output logic [COORD_BITS-1:0]                     out_near_x,
  output logic [COORD_BITS-1:0]                     out_near_y,
  output logic [2*COORD_BITS:0]                     out_dist_squared,
  output logic [COORD_BITS:0]                       out_dist_root
);

  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CB   = COORD_BITS;
  localparam int IDB  = ptns_pkg::ID_BITS;
  localparam int NIB  = ptns_pkg::NEXT_ID_BITS;
  localparam int SQW  = 2 * CB;
  localparam int DW   = 2 * CB + 1;
  localparam int RW   = CB + 1;
  localparam int VW   = 2 * RW;
  localparam int RMW  = RW + 3;
  localparam int RCW  = $clog2(RW);
  localparam int MW   = IDB + 2 * CB;

  ptns_pkg::state_t state_r, state_nxt;

  // request registers
  ptns_pkg::op_t    req_op_r, req_op_nxt;
  logic [CB-1:0]    req_x_r, req_x_nxt;
  logic [CB-1:0]    req_y_r, req_y_nxt;
  logic [IDB-1:0]   req_id_r, req_id_nxt;

  // table state
  logic [CAPACITY-1:0] slot_valid_r, slot_valid_nxt;
  logic [NIB-1:0]      next_ident_r, next_ident_nxt;
  logic [MW-1:0]       mem [CAPACITY];
  logic [MW-1:0]       rd_data_r;
  logic                mem_we;

  // scan and pipeline
  logic [IW-1:0]  scan_idx_r, scan_idx_nxt;
  logic           p1_vld_r, p1_ok_r;
  logic [IW-1:0]  p1_idx_r;
  logic           p2_vld_r, p2_ok_r;
  logic [IW-1:0]  p2_idx_r;
  logic [IDB-1:0] p2_id_r;
  logic [CB-1:0]  p2_x_r, p2_y_r, p2_dx_r, p2_dy_r;
  logic           p3_vld_r, p3_ok_r;
  logic [IW-1:0]  p3_idx_r;
  logic [IDB-1:0] p3_id_r;
  logic [CB-1:0]  p3_x_r, p3_y_r;
  logic [SQW-1:0] p3_sqx_r, p3_sqy_r;
  logic [DW-1:0]  p3_dist;
  logic [IDB-1:0] rd_id;
  logic [CB-1:0]  rd_x, rd_y;
  logic           pipe_empty;
  logic           scan_last;

  // best candidate
  logic           found_r, found_nxt;
  logic [IW-1:0]  best_idx_r, best_idx_nxt;
  logic [IDB-1:0] best_id_r, best_id_nxt;
  logic [CB-1:0]  best_x_r, best_x_nxt;
  logic [CB-1:0]  best_y_r, best_y_nxt;
  logic [DW-1:0]  best_d_r, best_d_nxt;

  // square root
  logic [VW-1:0]  sq_val_r, sq_val_nxt;
  logic [RMW-1:0] sq_rem_r, sq_rem_nxt;
  logic [RW-1:0]  sq_root_r, sq_root_nxt;
  logic [RCW-1:0] sq_cnt_r, sq_cnt_nxt;
  logic [RMW-1:0] rem_shift, trial, rem_step;
  logic           rem_ge;
  logic [RW-1:0]  root_step;
  logic           root_last;

  // result registers
  logic           out_valid_r, out_valid_nxt;
  ptns_pkg::status_t out_status_r, out_status_nxt;
  logic [IDB-1:0] out_id_r, out_id_nxt;
  logic [CB-1:0]  out_x_r, out_x_nxt;
  logic [CB-1:0]  out_y_r, out_y_nxt;
  logic [DW-1:0]  out_d_r, out_d_nxt;
  logic [RW-1:0]  out_root_r, out_root_nxt;

  logic accept;

  assign busy   = (state_r != ptns_pkg::S_IDLE);
  assign accept = start && !busy;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_id    = out_id_r;
  assign out_near_x       = out_x_r;
  assign out_near_y       = out_y_r;
  assign out_dist_squared = out_d_r;
  assign out_dist_root    = out_root_r;

  assign rd_id = rd_data_r[MW-1 -: IDB];
  assign rd_x  = rd_data_r[2*CB-1 -: CB];
  assign rd_y  = rd_data_r[CB-1:0];

  assign p3_dist    = DW'(p3_sqx_r) + DW'(p3_sqy_r);
  assign pipe_empty = !p1_vld_r && !p2_vld_r && !p3_vld_r;
  assign scan_last  = (scan_idx_r == IW'(CAPACITY - 1));

  assign rem_shift = {sq_rem_r[RMW-3:0], sq_val_r[VW-1 -: 2]};
  assign trial     = RMW'({sq_root_r, 2'b01});
  assign rem_ge    = (rem_shift >= trial);
  assign rem_step  = rem_ge ? (rem_shift - trial) : rem_shift;
  assign root_step = {sq_root_r[RW-2:0], rem_ge};
  assign root_last = (sq_cnt_r == RCW'(RW - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptns_pkg::S_IDLE: begin
        if (accept) state_nxt = ptns_pkg::S_SCAN;
      end
      ptns_pkg::S_SCAN: begin
        if (scan_last) state_nxt = ptns_pkg::S_DRAIN;
      end
      ptns_pkg::S_DRAIN: begin
        if (pipe_empty) state_nxt = ptns_pkg::S_FINISH;
      end
      ptns_pkg::S_FINISH: begin
        if (req_op_r == ptns_pkg::OP_QUERY && found_r) state_nxt = ptns_pkg::S_ROOT;
        else state_nxt = ptns_pkg::S_IDLE;
      end
      ptns_pkg::S_ROOT: begin
        if (root_last) state_nxt = ptns_pkg::S_IDLE;
      end
      default: state_nxt = ptns_pkg::S_IDLE;
    endcase
  end

  // datapath and result control
  always_comb begin
    req_op_nxt     = req_op_r;
    req_x_nxt      = req_x_r;
    req_y_nxt      = req_y_r;
    req_id_nxt     = req_id_r;
    slot_valid_nxt = slot_valid_r;
    next_ident_nxt = next_ident_r;
    mem_we         = 1'b0;
    scan_idx_nxt   = scan_idx_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_id_nxt    = best_id_r;
    best_x_nxt     = best_x_r;
    best_y_nxt     = best_y_r;
    best_d_nxt     = best_d_r;
    sq_val_nxt     = sq_val_r;
    sq_rem_nxt     = sq_rem_r;
    sq_root_nxt    = sq_root_r;
    sq_cnt_nxt     = sq_cnt_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_d_nxt      = out_d_r;
    out_root_nxt   = out_root_r;

    // candidate selection at the end of the pipeline
    if (p3_vld_r) begin
      case (req_op_r)
        ptns_pkg::OP_ADD: begin
          if (!found_r && !p3_ok_r) begin
            found_nxt    = 1'b1;
            best_idx_nxt = p3_idx_r;
          end
        end
        ptns_pkg::OP_DELETE: begin
          if (!found_r && p3_ok_r && (p3_id_r == req_id_r)) begin
            found_nxt    = 1'b1;
            best_idx_nxt = p3_idx_r;
          end
        end
        ptns_pkg::OP_QUERY: begin
          if (p3_ok_r && (!found_r || (p3_dist < best_d_r) ||
                          ((p3_dist == best_d_r) && (p3_id_r < best_id_r)))) begin
            found_nxt    = 1'b1;
            best_idx_nxt = p3_idx_r;
            best_id_nxt  = p3_id_r;
            best_x_nxt   = p3_x_r;
            best_y_nxt   = p3_y_r;
            best_d_nxt   = p3_dist;
          end
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      ptns_pkg::S_IDLE: begin
        if (accept) begin
          req_op_nxt   = ptns_pkg::op_t'(in_operation);
          req_x_nxt    = in_x_coord;
          req_y_nxt    = in_y_coord;
          req_id_nxt   = in_item_id;
          scan_idx_nxt = '0;
          found_nxt    = 1'b0;
        end
      end
      ptns_pkg::S_SCAN: begin
        scan_idx_nxt = IW'(scan_idx_r + 1'b1);
      end
      ptns_pkg::S_FINISH: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ptns_pkg::STAT_MISS;
        out_id_nxt     = '0;
        out_x_nxt      = '0;
        out_y_nxt      = '0;
        out_d_nxt      = '0;
        out_root_nxt   = '0;
        case (req_op_r)
          ptns_pkg::OP_ADD: begin
            if (!found_r) begin
              out_status_nxt = ptns_pkg::STAT_FULL;
            end else if (next_ident_r[NIB-1]) begin
              out_status_nxt = ptns_pkg::STAT_EXHAUST;
            end else begin
              out_status_nxt             = ptns_pkg::STAT_OK;
              out_id_nxt                 = next_ident_r[IDB-1:0];
              slot_valid_nxt[best_idx_r] = 1'b1;
              next_ident_nxt             = NIB'(next_ident_r + 1'b1);
              mem_we                     = 1'b1;
            end
          end
          ptns_pkg::OP_DELETE: begin
            if (found_r) begin
              out_status_nxt             = ptns_pkg::STAT_OK;
              out_id_nxt                 = req_id_r;
              slot_valid_nxt[best_idx_r] = 1'b0;
            end
          end
          ptns_pkg::OP_QUERY: begin
            if (found_r) begin
              out_valid_nxt = 1'b0;
              sq_val_nxt    = VW'(best_d_r);
              sq_rem_nxt    = '0;
              sq_root_nxt   = '0;
              sq_cnt_nxt    = '0;
            end
          end
          default: begin
          end
        endcase
      end
      ptns_pkg::S_ROOT: begin
        sq_val_nxt  = sq_val_r << 2;
        sq_rem_nxt  = rem_step;
        sq_root_nxt = root_step;
        sq_cnt_nxt  = RCW'(sq_cnt_r + 1'b1);
        if (root_last) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ptns_pkg::STAT_OK;
          out_id_nxt     = best_id_r;
          out_x_nxt      = best_x_r;
          out_y_nxt      = best_y_r;
          out_d_nxt      = best_d_r;
          out_root_nxt   = root_step;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ptns_pkg::S_IDLE;
      slot_valid_r <= '0;
      next_ident_r <= NIB'(1);
      p1_vld_r     <= 1'b0;
      p2_vld_r     <= 1'b0;
      p3_vld_r     <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_valid_r <= slot_valid_nxt;
      next_ident_r <= next_ident_nxt;
      p1_vld_r     <= (state_r == ptns_pkg::S_SCAN);
      p2_vld_r     <= p1_vld_r;
      p3_vld_r     <= p2_vld_r;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[best_idx_r] <= {next_ident_r[IDB-1:0], req_x_r, req_y_r};
    rd_data_r <= mem[scan_idx_r];
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_op_r     <= req_op_nxt;
    req_x_r      <= req_x_nxt;
    req_y_r      <= req_y_nxt;
    req_id_r     <= req_id_nxt;
    scan_idx_r   <= scan_idx_nxt;

    p1_ok_r      <= slot_valid_r[scan_idx_r];
    p1_idx_r     <= scan_idx_r;

    p2_ok_r      <= p1_ok_r;
    p2_idx_r     <= p1_idx_r;
    p2_id_r      <= rd_id;
    p2_x_r       <= rd_x;
    p2_y_r       <= rd_y;
    p2_dx_r      <= (rd_x >= req_x_r) ? (rd_x - req_x_r) : (req_x_r - rd_x);
    p2_dy_r      <= (rd_y >= req_y_r) ? (rd_y - req_y_r) : (req_y_r - rd_y);

    p3_ok_r      <= p2_ok_r;
    p3_idx_r     <= p2_idx_r;
    p3_id_r      <= p2_id_r;
    p3_x_r       <= p2_x_r;
    p3_y_r       <= p2_y_r;
    p3_sqx_r     <= SQW'(p2_dx_r) * SQW'(p2_dx_r);
    p3_sqy_r     <= SQW'(p2_dy_r) * SQW'(p2_dy_r);

    best_idx_r   <= best_idx_nxt;
    best_id_r    <= best_id_nxt;
    best_x_r     <= best_x_nxt;
    best_y_r     <= best_y_nxt;
    best_d_r     <= best_d_nxt;

    sq_val_r     <= sq_val_nxt;
    sq_rem_r     <= sq_rem_nxt;
    sq_root_r    <= sq_root_nxt;
    sq_cnt_r     <= sq_cnt_nxt;

    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_d_r      <= out_d_nxt;
    out_root_r   <= out_root_nxt;
  end

  // checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_vld_r || p2_vld_r || p3_vld_r) |-> busy)
    else $error("scan pipeline active while idle");

  a_ok_has_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ptns_pkg::STAT_OK) |-> (out_id_r != '0))
    else $error("successful request returned identifier zero");

  a_root_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((VW'(out_root_r) * VW'(out_root_r)) <= VW'(out_d_r)))
    else $error("square root too large");

  a_root_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (((VW+1)'(out_root_r) + 1'b1) * ((VW+1)'(out_root_r) + 1'b1) > (VW+1)'(out_d_r)))
    else $error("square root too small");

endmodule
`default_nettype wire
